FILE: sv/uidt_pkg.sv
package uidt_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths
    localparam int CMD_W       = 3;
    localparam int UID_W       = 32;
    localparam int TAG_W       = 16;
    localparam int EIDX_W      = 4;
    localparam int ECNT_W      = 5;

    // Command codes
    localparam logic [CMD_W-1:0] OP_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] OP_CHECK  = 3'd2;
    localparam logic [CMD_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] OP_READ   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [UID_W-1:0]  card_uid;
        logic [TAG_W-1:0]  card_tag_type;
        logic              card_valid;
        logic [EIDX_W-1:0] entry_index;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic [ECNT_W-1:0] entry_count;
        logic [UID_W-1:0]  read_uid;
        logic [TAG_W-1:0]  read_tag_type;
        logic              read_valid;
    } t_out;

    // One stored record
    typedef struct packed {
        logic [UID_W-1:0] uid;
        logic [TAG_W-1:0] tag;
        logic             vbit;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic cap;        // capture the input beat
        logic rd_next;    // read at the walk pointer, advance it
        logic rd_idx;     // read at the requested index
        logic append;     // write captured record at the end, count up
        logic shift_wr;   // write read data one place down
        logic dec_count;
        logic clr_count;
        logic set_res;
        logic res_ok;
        logic res_data;   // take read data into the result
        logic load_out;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             full;
        logic             idx_ok;
        logic             hit;
        logic             at_end;
        logic             dvld;
        logic             out_free;
    } t_stat;

endpackage

FILE: sv/uidt_ctrl.sv
module uidt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  uidt_pkg::t_stat i_stat,
    output uidt_pkg::t_ctl  o_ctl
);
    import uidt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.op) inside
                    OP_ADD:    n_state = i_stat.full ? S_DONE : S_SCAN;
                    OP_REMOVE,
                    OP_CHECK:  n_state = S_SCAN;
                    OP_READ:   n_state = i_stat.idx_ok ? S_READ : S_DONE;
                    default:   n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = (i_stat.op == OP_REMOVE) ? S_SHIFT : S_DONE;
                end else if (i_stat.at_end) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (i_stat.at_end) n_state = S_DONE;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_ctl.cap = i_in_valid;
            end
            S_DECODE: begin
                unique case (i_stat.op) inside
                    OP_ADD: begin
                        o_ctl.set_res = i_stat.full;
                    end
                    OP_REMOVE,
                    OP_CHECK: begin
                    end
                    OP_CLEAR: begin
                        o_ctl.clr_count = 1'b1;
                        o_ctl.set_res   = 1'b1;
                        o_ctl.res_ok    = 1'b1;
                    end
                    OP_READ: begin
                        o_ctl.rd_idx  = i_stat.idx_ok;
                        o_ctl.set_res = !i_stat.idx_ok;
                    end
                    default: begin
                        o_ctl.set_res = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    // a match ends an add or a check; a remove goes on to shift
                    o_ctl.set_res = (i_stat.op != OP_REMOVE);
                    o_ctl.res_ok  = (i_stat.op == OP_CHECK);
                end else if (i_stat.at_end) begin
                    o_ctl.append  = (i_stat.op == OP_ADD);
                    o_ctl.set_res = 1'b1;
                    o_ctl.res_ok  = (i_stat.op == OP_ADD);
                end else begin
                    o_ctl.rd_next = 1'b1;
                end
            end
            S_SHIFT: begin
                o_ctl.shift_wr = i_stat.dvld;
                if (i_stat.at_end) begin
                    o_ctl.dec_count = 1'b1;
                    o_ctl.set_res   = 1'b1;
                    o_ctl.res_ok    = 1'b1;
                end else begin
                    o_ctl.rd_next = 1'b1;
                end
            end
            S_READ: begin
                o_ctl.set_res  = 1'b1;
                o_ctl.res_ok   = 1'b1;
                o_ctl.res_data = 1'b1;
            end
            S_DONE: begin
                o_ctl.load_out = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: sv/uidt_dpath.sv
module uidt_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  uidt_pkg::t_ctl  i_ctl,
    output uidt_pkg::t_stat o_stat,
    input  uidt_pkg::t_in   i_in,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output uidt_pkg::t_out  o_out
);
    import uidt_pkg::*;

    localparam int CMP_W = (CNT_W > EIDX_W) ? CNT_W + 1 : EIDX_W + 1;

    t_rec             r_mem [MAX_ENTRIES];
    t_in              r_cmd;
    t_rec             r_rdata;
    t_rec             r_res_rec;
    t_out             r_out;
    logic             r_res_ok;
    logic             r_dvld;
    logic             r_out_vld;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_addr;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_addr;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_rec             wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] shift_pos;
    t_rec             cmd_rec;

    assign cmd_rec   = '{uid: r_cmd.card_uid, tag: r_cmd.card_tag_type, vbit: r_cmd.card_valid};
    // read data belongs to r_addr-1; it moves down to r_addr-2
    assign shift_pos = r_addr - CNT_W'(2);

    always_comb begin
        wr_en   = i_ctl.append | i_ctl.shift_wr;
        wr_addr = i_ctl.append ? IDX_W'(r_count) : IDX_W'(shift_pos);
        wr_data = i_ctl.append ? cmd_rec : r_rdata;
        rd_en   = i_ctl.rd_next | i_ctl.rd_idx;
        rd_addr = i_ctl.rd_next ? IDX_W'(r_addr) : IDX_W'(r_cmd.entry_index);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.clr_count)      n_count = '0;
        else if (i_ctl.append)    n_count = r_count + CNT_W'(1);
        else if (i_ctl.dec_count) n_count = r_count - CNT_W'(1);

        n_addr = r_addr;
        if (i_ctl.cap)          n_addr = '0;
        else if (i_ctl.rd_next) n_addr = r_addr + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_addr    <= '0;
            r_dvld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_addr    <= n_addr;
            r_dvld    <= rd_en;
            r_out_vld <= i_ctl.load_out | (r_out_vld & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) r_cmd <= i_in;
        if (i_ctl.set_res) begin
            r_res_ok  <= i_ctl.res_ok;
            r_res_rec <= i_ctl.res_data ? r_rdata : '0;
        end
        if (i_ctl.load_out) begin
            r_out.ok            <= r_res_ok;
            r_out.entry_count   <= ECNT_W'(r_count);
            r_out.read_uid      <= r_res_rec.uid;
            r_out.read_tag_type <= r_res_rec.tag;
            r_out.read_valid    <= r_res_rec.vbit;
        end
    end

    always_comb begin
        o_stat.op       = r_cmd.cmd;
        o_stat.full     = (r_count == CNT_W'(MAX_ENTRIES));
        o_stat.idx_ok   = (CMP_W'(r_cmd.entry_index) < CMP_W'(r_count));
        o_stat.hit      = r_dvld && (r_rdata.uid == r_cmd.card_uid);
        o_stat.at_end   = (r_addr >= r_count);
        o_stat.dvld     = r_dvld;
        o_stat.out_free = !r_out_vld || !i_out_stall;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

FILE: sv/uid_table_insert_remove_lookup_unit.sv
// Channel   Direction  Payload          Handshake
// -------   ---------  ---------------  ------------------------
// in        input      uidt_pkg::t_in   i_in_valid / o_in_stall
// out       output     uidt_pkg::t_out  o_out_valid / i_out_stall
//
// One command at a time, one record per cycle through the memory's single read port.
// Clear, an unused code, a full-table add and a read past the count are settled in decode;
// a read does one memory read; add and check walk the records to a match or the end;
// a remove shifts every later record down after its match. The input stalls until
// the result is loaded. A stalled result waits in the output register; the next one
// waits behind it. Reset (synchronous, active low) empties the table, not the memory.
module uid_table_insert_remove_lookup_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  uidt_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output uidt_pkg::t_out o_out
);
    import uidt_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    // Sequence each command: decode, walk, shift, finish.
    uidt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // Hold the records, the count, the walk pointer and the result register.
    uidt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    // An accepted beat blocks the input side on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // A failed command carries zero read fields.
    a_fail_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.ok |->
            (o_out.read_uid == '0) && (o_out.read_tag_type == '0) && !o_out.read_valid)
        else $error("read fields not zero on failed command");

    // The reported count never passes the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out.entry_count) <= MAX_ENTRIES))
        else $error("entry count beyond table size");

    // The datapath never writes and shifts in the same cycle.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.append && ctl.shift_wr))
        else $error("two writes in one cycle");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import uidt_pkg::*;

    localparam int     CLK_HALF     = 6;
    localparam longint LIMIT_NS     = 18_000_000;
    localparam int     POOL_SIZE    = 24;
    localparam int     PHASE_ITEMS  = 530;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     HOLD_AFTER   = 300;
    localparam int     TAIL_CYCLES  = 2 * MAX_ENTRIES + 16;
    // First command code that the block ignores; codes above it are ignored too.
    localparam logic [CMD_W-1:0] OP_UNUSED = 3'd5;

    logic   clk      = 1'b0;
    logic   rst_n    = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    t_in    in_beat  = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    t_out   out_beat;

    uid_table_insert_remove_lookup_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    // Shadow of the card table, updated in acceptance order.
    t_rec        card_tbl [MAX_ENTRIES];
    int          card_cnt = 0;

    t_in         cmd_q     [$];   // commands waiting to be offered
    t_out        reply_q   [$];   // predicted replies, oldest first
    logic [31:0] uid_pool  [POOL_SIZE];

    int          send_idle_pct = 9;
    int          recv_idle_pct = 74;
    int          errors        = 0;
    int          replies_seen  = 0;
    logic        in_took       = 1'b0;
    int          hold_left     = 0;
    logic        hold_done     = 1'b0;

    // Clock and the single reset pulse.
    initial begin
        forever #(CLK_HALF) clk = ~clk;
    end

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: a correct run finishes far earlier.
    initial begin
        #(LIMIT_NS);
        $display("tb NOT OK");
        $finish;
    end

    // Position of the first stored record carrying this UID, or -1.
    function automatic int uid_slot(logic [UID_W-1:0] uid);
        int k;
        for (k = 0; k < card_cnt; k++) begin
            if (card_tbl[k].uid == uid) begin
                return k;
            end
        end
        return -1;
    endfunction

    // Apply one command to the shadow table and return the reply it gives.
    function automatic t_out apply_card_cmd(t_in b);
        t_out r;
        int   hit;
        int   k;
        r   = '0;
        hit = uid_slot(b.card_uid);
        case (b.cmd)
            OP_ADD: begin
                // Refuse on a full table or a UID already present.
                if (card_cnt < MAX_ENTRIES && hit < 0) begin
                    card_tbl[card_cnt].uid  = b.card_uid;
                    card_tbl[card_cnt].tag  = b.card_tag_type;
                    card_tbl[card_cnt].vbit = b.card_valid;
                    card_cnt++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                // Close the gap: every later record moves down one place.
                if (hit >= 0) begin
                    for (k = hit; k < card_cnt - 1; k++) begin
                        card_tbl[k] = card_tbl[k + 1];
                    end
                    card_cnt--;
                    r.ok = 1'b1;
                end
            end
            OP_CHECK: begin
                r.ok = (hit >= 0);
            end
            OP_CLEAR: begin
                // Stale records stay in memory but drop out of reach.
                card_cnt = 0;
                r.ok     = 1'b1;
            end
            OP_READ: begin
                if (int'(b.entry_index) < card_cnt) begin
                    r.ok            = 1'b1;
                    r.read_uid      = card_tbl[b.entry_index].uid;
                    r.read_tag_type = card_tbl[b.entry_index].tag;
                    r.read_valid    = card_tbl[b.entry_index].vbit;
                end
            end
            default: begin
                // Unused codes leave everything alone.
            end
        endcase
        r.entry_count = ECNT_W'(card_cnt);
        return r;
    endfunction

    function automatic t_in card_cmd(logic [CMD_W-1:0] op, logic [UID_W-1:0] uid,
                                     logic [TAG_W-1:0] tag, logic vbit,
                                     logic [EIDX_W-1:0] idx);
        t_in b;
        b.cmd           = op;
        b.card_uid      = uid;
        b.card_tag_type = tag;
        b.card_valid    = vbit;
        b.entry_index   = idx;
        return b;
    endfunction

    task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    function automatic logic [UID_W-1:0] pick_uid();
        if ($urandom_range(99) < 85) begin
            return uid_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    // Queue a random mix. Most commands work on a small pool of UIDs so that
    // adds collide, removes hit and the table keeps running full; the rest is
    // noise over every code and every bit.
    task automatic queue_random_cmds(int n);
        int left;
        int roll;
        int base;
        int j;
        left = n;
        while (left > 0) begin
            roll = $urandom_range(99);
            if ($urandom_range(99) < 3) begin
                uid_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
            end
            if (roll < 4) begin
                // Fill burst: empty the table, then add one more than it holds.
                cmd_q.push_back(card_cmd(OP_CLEAR, $urandom, TAG_W'($urandom),
                                         1'($urandom), EIDX_W'($urandom)));
                base = $urandom_range(POOL_SIZE - 1);
                for (j = 0; j <= MAX_ENTRIES; j++) begin
                    cmd_q.push_back(card_cmd(OP_ADD, uid_pool[(base + j) % POOL_SIZE],
                                             TAG_W'($urandom), 1'($urandom),
                                             EIDX_W'($urandom)));
                end
                left -= MAX_ENTRIES + 2;
            end else begin
                if (roll < 38) begin
                    cmd_q.push_back(card_cmd(OP_ADD, pick_uid(), TAG_W'($urandom),
                                             1'($urandom), EIDX_W'($urandom)));
                end else if (roll < 58) begin
                    cmd_q.push_back(card_cmd(OP_REMOVE, pick_uid(), TAG_W'($urandom),
                                             1'($urandom), EIDX_W'($urandom)));
                end else if (roll < 73) begin
                    cmd_q.push_back(card_cmd(OP_CHECK, pick_uid(), TAG_W'($urandom),
                                             1'($urandom), EIDX_W'($urandom)));
                end else if (roll < 92) begin
                    cmd_q.push_back(card_cmd(OP_READ, $urandom, TAG_W'($urandom),
                                             1'($urandom), EIDX_W'($urandom)));
                end else if (roll < 94) begin
                    cmd_q.push_back(card_cmd(OP_CLEAR, $urandom, TAG_W'($urandom),
                                             1'($urandom), EIDX_W'($urandom)));
                end else begin
                    cmd_q.push_back(card_cmd(CMD_W'($urandom), $urandom,
                                             TAG_W'($urandom), 1'($urandom),
                                             EIDX_W'($urandom)));
                end
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || in_valid || reply_q.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Stimulus: directed opening, then three random phases with different
    // idling, then the closing check.
    initial begin
        int p;
        for (p = 0; p < POOL_SIZE; p++) begin
            uid_pool[p] = $urandom;
        end

        // Empty table: read, remove and check all miss.
        cmd_q.push_back(card_cmd(OP_READ,   32'h0, 16'h0, 1'b0, 4'd0));
        cmd_q.push_back(card_cmd(OP_REMOVE, 32'h0, 16'h0, 1'b0, 4'd0));
        cmd_q.push_back(card_cmd(OP_CHECK,  32'h0, 16'h0, 1'b0, 4'd0));
        // Extreme records, then a duplicate UID that must be refused.
        cmd_q.push_back(card_cmd(OP_ADD,    32'h0, 16'h0, 1'b0, 4'd15));
        cmd_q.push_back(card_cmd(OP_ADD,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, 4'd15));
        cmd_q.push_back(card_cmd(OP_ADD,    32'hFFFF_FFFF, 16'h1234, 1'b0, 4'd0));
        cmd_q.push_back(card_cmd(OP_CHECK,  32'hFFFF_FFFF, 16'h0, 1'b0, 4'd0));
        cmd_q.push_back(card_cmd(OP_READ,   32'h0, 16'h0, 1'b0, 4'd1));
        cmd_q.push_back(card_cmd(OP_READ,   32'hFFFF_FFFF, 16'hFFFF, 1'b1, 4'd15));
        // Remove the head record; the tail must shift down to position 0.
        cmd_q.push_back(card_cmd(OP_REMOVE, 32'h0, 16'h0, 1'b0, 4'd0));
        cmd_q.push_back(card_cmd(OP_READ,   32'h0, 16'h0, 1'b0, 4'd0));
        cmd_q.push_back(card_cmd(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 4'd0));
        cmd_q.push_back(card_cmd(CMD_W'(OP_UNUSED + 1), 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                 4'd0));
        cmd_q.push_back(card_cmd(CMD_W'(OP_UNUSED + 2), 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                 4'd15));
        // Clear leaves stale data behind; it must not be reachable.
        cmd_q.push_back(card_cmd(OP_CLEAR,  32'h0, 16'h0, 1'b0, 4'd0));
        cmd_q.push_back(card_cmd(OP_READ,   32'h0, 16'h0, 1'b0, 4'd0));
        cmd_q.push_back(card_cmd(OP_CHECK,  32'hFFFF_FFFF, 16'h0, 1'b0, 4'd0));
        cmd_q.push_back(card_cmd(OP_REMOVE, 32'hFFFF_FFFF, 16'h0, 1'b0, 4'd0));

        // Phase 0: busy sender, lazy receiver (the long hold-off lands here).
        queue_random_cmds(PHASE_ITEMS);
        wait_drained();
        // Phase 1: lazy sender, busy receiver.
        send_idle_pct = 74;
        recv_idle_pct = 9;
        queue_random_cmds(PHASE_ITEMS);
        wait_drained();
        // Phase 2: full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_cmds(PHASE_ITEMS);
        wait_drained();

        // Let any stray reply show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Command driver: advance on the falling edge. Hold a beat until it is
    // taken; offer the next one or idle only after acceptance.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_beat  <= cmd_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Reply receiver: random stall, plus one long hold-off after a few
    // hundred replies so the block backs up and stalls its command side.
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && replies_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: on the rising edge, predict each accepted command beat and
    // check each accepted reply beat against the oldest prediction.
    always @(posedge clk) begin
        t_out want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                reply_q.push_back(apply_card_cmd(in_beat));
            end
            if (out_valid && !out_stall) begin
                replies_seen <= replies_seen + 1;
                if (reply_q.size() == 0) begin
                    $display("%0t: reply with none expected, got 0x%0h", $time, out_beat);
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    field_check("ok",            32'(want.ok),            32'(out_beat.ok));
                    field_check("entry_count",   32'(want.entry_count),
                                32'(out_beat.entry_count));
                    field_check("read_uid",      want.read_uid,           out_beat.read_uid);
                    field_check("read_tag_type", 32'(want.read_tag_type),
                                32'(out_beat.read_tag_type));
                    field_check("read_valid",    32'(want.read_valid),
                                32'(out_beat.read_valid));
                end
            end
        end
        in_took <= rst_n && in_valid && !in_stall;
    end

endmodule
